// ----- hw/rtl/srd_pkg.sv -----
// srd_pkg: shared types, codes and constants of the servo reply deframer.
// No dependencies; used by srd_core, srd_fifo and servo_reply_deframer.
package srd_pkg;

	// frame layout
	localparam int unsigned MAX_FRAME      = 64;
	localparam logic [7:0]  HDR_FIRST      = 8'h05;
	localparam logic [7:0]  HDR_SECOND     = 8'h1C;
	localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
	localparam logic [6:0]  OFF_SIZE       = 7'd3;
	localparam logic [6:0]  OFF_AFTER_HDR  = 7'd2;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

	// result queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HUNT = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_TIMEOUT = 2'd2,
		KIND_LONG    = 2'd3
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [5:0]  off;
		logic [6:0]  len;
	} res_t;

	// up to two results produced by one input beat
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ----- hw/rtl/srd_core.sv -----
// srd_core: receiver state (phase, header sync, byte count, length, ticks)
// and result generation for one input beat. Depends on srd_pkg.
module srd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          cmd,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output srd_pkg::push_t      push
);

	srd_pkg::phase_t phase_q, phase_d;
	logic            saw_hdr_q, saw_hdr_d;
	logic [6:0]      taken_q, taken_d;
	logic [8:0]      exp_len_q, exp_len_d;
	logic [15:0]     elapsed_q, elapsed_d;
	logic [15:0]     timeout_q;

	// shared decode
	logic       timed_out;
	logic       hdr_hit;
	logic [8:0] size_len;
	logic [8:0] cur_len;
	logic       too_long;
	logic       last_byte;
	logic [8:0] taken_nx;

	assign timed_out = elapsed_q >= timeout_q;
	assign hdr_hit   = saw_hdr_q && (rx_byte == srd_pkg::HDR_SECOND);
	assign size_len  = srd_pkg::FRAME_OVERHEAD + {1'b0, rx_byte};
	assign cur_len   = (taken_q == srd_pkg::OFF_SIZE) ? size_len : exp_len_q;
	assign too_long  = (taken_q == srd_pkg::OFF_SIZE) &&
		(size_len > 9'(srd_pkg::MAX_FRAME));
	assign taken_nx  = {2'b00, taken_q} + 9'd1;
	assign last_byte = (taken_q >= srd_pkg::OFF_SIZE) && (taken_nx >= cur_len);

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= srd_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		saw_hdr_d = saw_hdr_q;
		taken_d   = taken_q;
		exp_len_d = exp_len_q;
		elapsed_d = elapsed_q;
		if (accept) begin
			if (cmd == srd_pkg::CMD_START) begin
				phase_d   = srd_pkg::PH_HUNT;
				saw_hdr_d = 1'b0;
				taken_d   = '0;
				exp_len_d = '0;
				elapsed_d = '0;
			end else if (phase_q != srd_pkg::PH_IDLE) begin
				case (cmd)
					srd_pkg::CMD_TICK: begin
						if (timed_out) begin
							phase_d = srd_pkg::PH_IDLE;
						end else begin
							elapsed_d = elapsed_q + 16'd1;
						end
					end
					srd_pkg::CMD_BYTE: begin
						if (phase_q == srd_pkg::PH_HUNT) begin
							if (hdr_hit) begin
								saw_hdr_d = 1'b0;
								phase_d   = srd_pkg::PH_BODY;
								taken_d   = srd_pkg::OFF_AFTER_HDR;
							end else begin
								saw_hdr_d = (rx_byte == srd_pkg::HDR_FIRST);
							end
						end else begin
							if (taken_q == srd_pkg::OFF_SIZE) begin
								exp_len_d = size_len;
							end
							if (too_long) begin
								phase_d = srd_pkg::PH_IDLE;
							end else begin
								taken_d = taken_nx[6:0];
								if (last_byte) begin
									phase_d = srd_pkg::PH_IDLE;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// results of this beat
	always_comb begin
		push    = '0;
		push.r0 = '{kind: srd_pkg::KIND_BYTE, data: rx_byte,
			off: taken_q[5:0], len: 7'd0};
		push.r1 = '{kind: srd_pkg::KIND_BYTE, data: srd_pkg::HDR_SECOND,
			off: 6'd1, len: 7'd0};
		if (accept && (phase_q != srd_pkg::PH_IDLE)) begin
			case (cmd)
				srd_pkg::CMD_TICK: begin
					if (timed_out) begin
						push.n  = 2'd1;
						push.r0 = '{kind: srd_pkg::KIND_TIMEOUT, data: 8'd0,
							off: 6'd0, len: 7'd0};
					end
				end
				srd_pkg::CMD_BYTE: begin
					if (phase_q == srd_pkg::PH_HUNT) begin
						if (hdr_hit) begin
							push.n       = 2'd2;
							push.r0.data = srd_pkg::HDR_FIRST;
							push.r0.off  = 6'd0;
						end
					end else begin
						push.n = 2'd1;
						if (too_long) begin
							push.r0.kind = srd_pkg::KIND_LONG;
						end else if (last_byte) begin
							push.r0.kind = srd_pkg::KIND_DONE;
							push.r0.len  = cur_len[6:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= srd_pkg::PH_IDLE;
			saw_hdr_q <= 1'b0;
			taken_q   <= '0;
			exp_len_q <= '0;
			elapsed_q <= '0;
		end else begin
			phase_q   <= phase_d;
			saw_hdr_q <= saw_hdr_d;
			taken_q   <= taken_d;
			exp_len_q <= exp_len_d;
			elapsed_q <= elapsed_d;
		end
	end

`ifndef SYNTH
	// in body the byte count never runs past the longest frame
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == srd_pkg::PH_BODY) |-> (taken_q < 7'(srd_pkg::MAX_FRAME)))
		else $error("byte count past frame limit");
	// a sync leaves the receiver in body at offset two
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |=> (phase_q == srd_pkg::PH_BODY &&
			taken_q == srd_pkg::OFF_AFTER_HDR))
		else $error("header sync did not enter body");
	// a completed frame reports a length the counter reached
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd1 && push.r0.kind == srd_pkg::KIND_DONE) |=>
			(phase_q == srd_pkg::PH_IDLE && {2'b00, taken_q} == $past(cur_len)))
		else $error("complete frame length mismatch");
`endif

endmodule

// ----- hw/rtl/srd_fifo.sv -----
// srd_fifo: small result queue, takes up to two results per cycle and
// delivers one per cycle on the output handshake. Depends on srd_pkg.
module srd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  srd_pkg::push_t push,
	input  logic           pop,
	output logic           room2,
	output logic           not_empty,
	output srd_pkg::res_t  head
);

	srd_pkg::res_t                mem_q [srd_pkg::QDEPTH];
	logic [srd_pkg::QPTR_W-1:0]   rd_ptr_q, wr_ptr_q, wr_ptr_p1;
	logic [srd_pkg::QCNT_W-1:0]   count_q;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign room2     = count_q <= srd_pkg::QCNT_W'(srd_pkg::QDEPTH - 2);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + srd_pkg::QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + srd_pkg::QCNT_W'(push.n)
				- srd_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |->
			(count_q + srd_pkg::QCNT_W'(push.n) - srd_pkg::QCNT_W'(pop)
				<= srd_pkg::QCNT_W'(srd_pkg::QDEPTH)))
		else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("result queue underflow");
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(not_empty && !pop) |=> $stable(head))
		else $error("queued head changed while waiting");
`endif

endmodule

// ----- hw/rtl/servo_reply_deframer.sv -----
// servo_reply_deframer: top level of the servo reply deframer.
// Depends on srd_pkg, srd_core and srd_fifo.
//
// Input beats (cmd, rx_byte) arrive on in_valid/in_ready: start arms the
// receiver, a byte is searched for the 0x05 0x1C header and then framed,
// a tick advances the timeout counter. Result beats (kind, frame_byte,
// byte_offset, frame_length) leave on out_valid/out_ready.
// cfg_we/cfg_wdata write timeout_ticks (reset 100); write only when idle.
// A result enters the result queue when its input beat is taken.
// Throughput: one input beat per cycle while in_ready is high; the header
// beat yields two results, so the output, one per cycle, sets the pace.
// A four-entry result queue sits between the sides; in_ready is high
// while it has room for two results, so a stalled receiver backs up
// into in_ready after a few beats and nothing is lost.
// Reset clears the receiver to idle, empties the queue and restores the
// timeout register.
module servo_reply_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  frame_byte,
	output logic [5:0]  byte_offset,
	output logic [6:0]  frame_length,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	srd_pkg::push_t push;
	srd_pkg::res_t  head;
	logic           room2;
	logic           accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = room2;

	srd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push)
	);

	srd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && out_ready),
		.room2     (room2),
		.not_empty (out_valid),
		.head      (head)
	);

	// result beat fields
	assign kind         = head.kind;
	assign frame_byte   = head.data;
	assign byte_offset  = head.off;
	assign frame_length = head.len;

endmodule

// ----- sim/servo_reply_deframer_tb.sv -----
`timescale 1ns / 1ps
// servo_reply_deframer_tb: self-checking testbench for the servo reply deframer.
// Depends on srd_pkg and servo_reply_deframer; replies are predicted by a scoreboard class.

module servo_reply_deframer_tb;
	import srd_pkg::*;

	localparam logic [1:0] CMD_UNUSED      = 2'd3;
	localparam int         CYCLE_LIMIT     = 400000;
	localparam int         DRAIN_SETTLE    = 4;
	localparam int         BEATS_PER_PHASE = 410;
	localparam int         HOLD_CYCLES     = 400;
	localparam int         GAP_CAP         = 30;

	// predicts reply beats from accepted input beats and checks what comes out
	class reply_tracker;
		res_t        expected_replies[$];
		logic [15:0] timeout_ticks;
		phase_t      rx_phase;
		bit          saw_first;
		logic [6:0]  taken;
		logic [8:0]  frame_total;
		logic [15:0] elapsed;
		int          errors;
		int          replies;
		int          frames_done;
		int          timeouts;
		int          oversize;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			rx_phase = PH_IDLE;
			clear_frame();
			errors = 0;
			replies = 0;
			frames_done = 0;
			timeouts = 0;
			oversize = 0;
		endfunction

		function void clear_frame();
			saw_first = 1'b0;
			taken = '0;
			frame_total = '0;
			elapsed = '0;
		endfunction

		function void set_timeout(logic [15:0] v);
			timeout_ticks = v;
		endfunction

		function void push_reply(kind_t k, logic [7:0] d, logic [5:0] o, logic [6:0] l);
			res_t r;
			r.kind = k;
			r.data = d;
			r.off = o;
			r.len = l;
			expected_replies.push_back(r);
		endfunction

		// advance the receiver by one accepted input beat
		function void take_beat(logic [1:0] c, logic [7:0] b);
			logic [6:0] off;
			if (c == CMD_START) begin
				clear_frame();
				rx_phase = PH_HUNT;
				return;
			end
			if (rx_phase == PH_IDLE || c == CMD_UNUSED)
				return;

			// tick: timeout once the count has reached the limit
			if (c == CMD_TICK) begin
				if (elapsed >= timeout_ticks) begin
					rx_phase = PH_IDLE;
					push_reply(KIND_TIMEOUT, 8'd0, 6'd0, 7'd0);
				end else begin
					elapsed++;
				end
				return;
			end

			// header search, one byte at a time
			if (rx_phase == PH_HUNT) begin
				if (saw_first && b == HDR_SECOND) begin
					saw_first = 1'b0;
					rx_phase = PH_BODY;
					taken = OFF_AFTER_HDR;
					push_reply(KIND_BYTE, HDR_FIRST, 6'd0, 7'd0);
					push_reply(KIND_BYTE, HDR_SECOND, 6'd1, 7'd0);
				end else begin
					saw_first = (b == HDR_FIRST);
				end
				return;
			end

			// body: size byte at offset 3 sets the length
			off = taken;
			if (off == OFF_SIZE) begin
				frame_total = FRAME_OVERHEAD + b;
				if (frame_total > MAX_FRAME) begin
					rx_phase = PH_IDLE;
					push_reply(KIND_LONG, b, 6'(OFF_SIZE), 7'd0);
					return;
				end
			end
			taken = off + 7'd1;
			if (off >= OFF_SIZE && taken >= frame_total) begin
				rx_phase = PH_IDLE;
				push_reply(KIND_DONE, b, off[5:0], frame_total[6:0]);
			end else begin
				push_reply(KIND_BYTE, b, off[5:0], 7'd0);
			end
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(res_t got);
			res_t want;
			if (expected_replies.size() == 0) begin
				$error("reply with none expected: kind %0d byte 0x%02h offset %0d length %0d",
					got.kind, got.data, got.off, got.len);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			replies++;
			check_field("kind", want.kind, got.kind);
			check_field("frame_byte", want.data, got.data);
			check_field("byte_offset", want.off, got.off);
			check_field("frame_length", want.len, got.len);
			case (want.kind)
				KIND_DONE:    frames_done++;
				KIND_TIMEOUT: timeouts++;
				KIND_LONG:    oversize++;
				default:      ;
			endcase
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_START;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  frame_byte;
	logic [5:0]  byte_offset;
	logic [6:0]  frame_length;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	reply_tracker tracker;
	res_t         seen_reply;
	int           sender_idle_pct = 0;
	int           stall_pct = 0;
	int           hold_left = 0;
	int           beats_sent = 0;
	int           cycle_count = 0;

	// opening beats: idle input, repeated header byte, shortest frame,
	// broken header, start while busy, oversize frame
	logic [9:0] opening_beats [$] = '{
		{CMD_BYTE, HDR_FIRST}, {CMD_TICK, 8'h00}, {CMD_UNUSED, 8'hFF},
		{CMD_START, 8'hFF}, {CMD_BYTE, HDR_FIRST}, {CMD_BYTE, HDR_FIRST},
		{CMD_BYTE, HDR_SECOND}, {CMD_BYTE, 8'hFF}, {CMD_BYTE, 8'h00},
		{CMD_TICK, 8'h00}, {CMD_UNUSED, 8'h00}, {CMD_BYTE, 8'hA5},
		{CMD_START, 8'h00}, {CMD_BYTE, HDR_FIRST}, {CMD_BYTE, 8'h33},
		{CMD_BYTE, HDR_SECOND}, {CMD_BYTE, HDR_FIRST}, {CMD_BYTE, HDR_SECOND},
		{CMD_BYTE, 8'h00}, {CMD_START, 8'h00}, {CMD_BYTE, HDR_FIRST},
		{CMD_BYTE, HDR_SECOND}, {CMD_BYTE, 8'h11}, {CMD_BYTE, 8'h3C}
	};

	servo_reply_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.frame_byte   (frame_byte),
		.byte_offset  (byte_offset),
		.frame_length (frame_length),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("watchdog: no finish within %0d cycles", CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// beat monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.take_beat(cmd, rx_byte);
			if (out_valid && out_ready) begin
				seen_reply.kind = kind_t'(kind);
				seen_reply.data = frame_byte;
				seen_reply.off = byte_offset;
				seen_reply.len = frame_length;
				tracker.check_reply(seen_reply);
			end
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	// offer one input beat after a random gap, return once accepted
	task automatic send_item(input logic [1:0] c, input logic [7:0] b);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		rx_byte = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// sender pauses until every predicted reply is out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (tracker.expected_replies.size() > 0)
			@(negedge clk);
		repeat (DRAIN_SETTLE) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_timeout(v);
	endtask

	// content size: mostly short, sometimes the largest legal, sometimes oversize
	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return MAX_FRAME - FRAME_OVERHEAD;
		if (r < 6)
			return 255;
		if (r < 10)
			return $urandom_range(MAX_FRAME - FRAME_OVERHEAD + 1, 254);
		if (r < 20)
			return $urandom_range(9, MAX_FRAME - FRAME_OVERHEAD - 1);
		return $urandom_range(0, 8);
	endfunction

	// one armed wait: noise, header, body; some cut short, some timed out
	task automatic send_frame();
		int r;
		int pick;
		int size;
		int body_end;
		r = $urandom_range(99);
		send_item(CMD_START, 8'($urandom));
		repeat ((r < 10) ? $urandom_range(1, 8) : $urandom_range(0, 2)) begin
			pick = $urandom_range(99);
			if (pick < 25)
				send_item(CMD_TICK, 8'($urandom));
			else if (pick < 30)
				send_item(CMD_UNUSED, 8'($urandom));
			else if (pick < 45)
				send_item(CMD_BYTE, HDR_FIRST);
			else
				send_item(CMD_BYTE, 8'($urandom));
		end
		if (r < 10)
			return;
		if ($urandom_range(9) == 0)
			send_item(CMD_BYTE, HDR_FIRST);
		send_item(CMD_BYTE, HDR_FIRST);
		send_item(CMD_BYTE, HDR_SECOND);

		// tick burst past the limit; the rest of the frame is then ignored
		if (r >= 18 && r < 26 && tracker.timeout_ticks <= 40)
			repeat (tracker.timeout_ticks + 2) send_item(CMD_TICK, 8'($urandom));

		size = pick_size();
		body_end = size + FRAME_OVERHEAD;
		if (r < 18)
			body_end = $urandom_range(3, body_end - 1);
		for (int off = 2; off < body_end; off++) begin
			if ($urandom_range(99) < 6)
				send_item(CMD_TICK, 8'($urandom));
			if ($urandom_range(99) < 2)
				send_item(CMD_UNUSED, 8'($urandom));
			send_item(CMD_BYTE, (off == OFF_SIZE) ? size[7:0] : 8'($urandom));
			if (off == OFF_SIZE && size + FRAME_OVERHEAD > MAX_FRAME)
				break;
		end
		if ($urandom_range(99) < 5)
			send_item(CMD_BYTE, 8'($urandom));
	endtask

	initial begin
		int target;
		int idle_by_phase[4];
		int stall_by_phase[4];
		logic [15:0] timeout_by_phase[4];
		idle_by_phase = '{0, 67, 0, 32};
		stall_by_phase = '{0, 0, 67, 32};
		timeout_by_phase = '{16'd12, 16'hFFFF, 16'd3, 16'($urandom_range(20, 400))};
		tracker = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed beats at the reset timeout
		foreach (opening_beats[i])
			send_item(opening_beats[i][9:8], opening_beats[i][7:0]);

		// zero limit: the first tick times out
		wait_drained();
		write_timeout(16'd0);
		send_item(CMD_START, 8'h00);
		send_item(CMD_TICK, 8'h00);

		// limit of one: the second tick times out
		wait_drained();
		write_timeout(16'd1);
		send_item(CMD_START, 8'h00);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);

		// random frames under each idling pattern
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			write_timeout(timeout_by_phase[p]);
			sender_idle_pct = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			if (p == 0) begin
				// long receiver hold-off: queue fills and input backs up
				hold_left = HOLD_CYCLES;
				repeat (4) send_frame();
				wait_drained();
			end
			target = beats_sent + BEATS_PER_PHASE;
			while (beats_sent < target)
				send_frame();
		end
		wait_drained();

		$display("run: %0d input beats, %0d replies checked", beats_sent, tracker.replies);
		$display("     %0d complete frames, %0d timeouts, %0d oversize frames",
			tracker.frames_done, tracker.timeouts, tracker.oversize);
		if (tracker.errors == 0 && tracker.expected_replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
